[hdl/ultrasonic_range_cutoff_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the ultrasonic range unit
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_CUTOFF_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGE_CUTOFF_UNIT_ASSERT_SVH

// same-cycle implication or plain property
`define URC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent this cycle, consequent the next
`define URC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/urc_pkg.sv]
// ---------------------------------------------------------------------------
// urc_pkg
// Types and constants shared by the ultrasonic range unit.
// ---------------------------------------------------------------------------
package urc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CM_DIVISOR     = 58;
  localparam int unsigned DIST_W         = 11;
  localparam logic [DIST_W-1:0] DIST_MAX = 11'h7FF;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned TIMER_W        = 16;

  localparam logic [7:0]        TRIGGER_US_RST = 8'd10;
  localparam logic [15:0]       LISTEN_US_RST  = 16'd30000;
  localparam logic [15:0]       HOLD_US_RST    = 16'd10000;
  localparam logic [DIST_W-1:0] NEAR_CM_RST    = 11'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_US = 2'd0,
    CFG_LISTEN_US  = 2'd1,
    CFG_HOLD_US    = 2'd2,
    CFG_NEAR_CM    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_TRIG   = 2'd0,
    PH_LISTEN = 2'd1,
    PH_HOLD   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0]        trigger_us;
    logic [15:0]       listen_us;
    logic [15:0]       hold_us;
    logic [DIST_W-1:0] near_cm;
  } cfg_t;

  typedef struct packed {
    logic              trigger_out;
    logic              motor_on;
    logic              led_out;
    logic [DIST_W-1:0] distance_cm;
    logic              distance_update;
  } res_t;

endpackage

[hdl/ultrasonic_range_cutoff_unit.sv]
// ---------------------------------------------------------------------------
// ultrasonic_range_cutoff_unit
// Echo ranging controller: trigger, listen and hold phases per tick request.
// ---------------------------------------------------------------------------
// Each result is registered in the result buffer before it reaches the outputs.
// Throughput: one request per cycle; the two-entry result buffer holds
// results while the output stalls, and input stall rises only when it is full.
// Reset (asynchronous, active low): trigger phase, counters and core registers
// cleared, configuration back to its default values, buffer empty.
module ultrasonic_range_cutoff_unit #(
  parameter int unsigned COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           echo_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           trigger_out_o,
  output logic                           motor_on_o,
  output logic                           led_out_o,
  output logic [urc_pkg::DIST_W-1:0]     distance_cm_o,
  output logic                           distance_update_o
);
  import urc_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_buf;
  logic accept;
  logic buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i & ~buf_full;

  urc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  urc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .tick_i (accept),
    .echo_i (echo_level_i),
    .res_o  (res)
  );

  urc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_buf)
  );

  assign trigger_out_o     = res_buf.trigger_out;
  assign motor_on_o        = res_buf.motor_on;
  assign led_out_o         = res_buf.led_out;
  assign distance_cm_o     = res_buf.distance_cm;
  assign distance_update_o = res_buf.distance_update;

endmodule

[hdl/urc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// urc_cfg_regs
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module urc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0]    index_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0]   data_i,
  output urc_pkg::cfg_t                    cfg_o
);
  import urc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(index_i))
        CFG_TRIGGER_US: cfg_d.trigger_us = data_i[7:0];
        CFG_LISTEN_US:  cfg_d.listen_us  = data_i;
        CFG_HOLD_US:    cfg_d.hold_us    = data_i;
        CFG_NEAR_CM:    cfg_d.near_cm    = data_i[DIST_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_us <= TRIGGER_US_RST;
      cfg_q.listen_us  <= LISTEN_US_RST;
      cfg_q.hold_us    <= HOLD_US_RST;
      cfg_q.near_cm    <= NEAR_CM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/urc_core.sv]
// ---------------------------------------------------------------------------
// urc_core
// Phase sequencer, echo width counter and distance conversion; one tick
// per accepted request.
// ---------------------------------------------------------------------------
module urc_core #(
  parameter int unsigned COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  urc_pkg::cfg_t cfg_i,
  input  logic          tick_i,
  input  logic          echo_i,
  output urc_pkg::res_t res_o
);
  import urc_pkg::*;

  `include "ultrasonic_range_cutoff_unit_assert.svh"

  localparam int unsigned SHIFT = COUNT_BITS + 6;
  localparam int unsigned QW    = COUNT_BITS - 5;
  // ceil(2^SHIFT / 58): exact quotient for any width below 2^COUNT_BITS
  localparam logic [COUNT_BITS:0] RECIP =
    (COUNT_BITS+1)'(((64'd1 << SHIFT) + 64'(CM_DIVISOR) - 64'd1) / 64'(CM_DIVISOR));
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  phase_e              phase_q, phase_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic                echo_prev_q;
  logic                in_pulse_q, in_pulse_d;
  logic [COUNT_BITS-1:0] pcount_q, pcount_d;
  logic [COUNT_BITS-1:0] width_q, width_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic                motor_q, motor_d;
  logic                led_q, led_d;

  logic [TIMER_W:0]    timer_inc;
  logic [7:0]          trig_len;
  logic [TIMER_W-1:0]  listen_len;
  logic                rise, fall;
  logic                hold_end;
  logic                trig;
  logic                update;
  logic [2*COUNT_BITS:0] product;
  logic [QW-1:0]       quot;
  logic [QW+DIST_W-1:0] quot_ext;
  logic [DIST_W-1:0]   dist_calc;

  assign timer_inc  = {1'b0, timer_q} + {{TIMER_W{1'b0}}, 1'b1};
  assign trig_len   = (cfg_i.trigger_us == 8'd0) ? 8'd1 : cfg_i.trigger_us;
  assign listen_len = (cfg_i.listen_us == 16'd0) ? 16'd1 : cfg_i.listen_us;
  assign rise       = echo_i & ~echo_prev_q;
  assign fall       = ~echo_i & echo_prev_q;

  // width / 58 by reciprocal multiply, clamped to the output range
  assign product   = {{(COUNT_BITS+1){1'b0}}, width_d} * {{COUNT_BITS{1'b0}}, RECIP};
  assign quot      = product[SHIFT +: QW];
  assign quot_ext  = {{DIST_W{1'b0}}, quot};
  assign dist_calc = (quot_ext > {{QW{1'b0}}, DIST_MAX}) ? DIST_MAX : quot_ext[DIST_W-1:0];

  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_q;
    in_pulse_d = in_pulse_q;
    pcount_d   = pcount_q;
    width_d    = width_q;
    dist_d     = dist_q;
    motor_d    = motor_q;
    led_d      = led_q;
    hold_end   = 1'b0;

    unique case (phase_q)
      PH_LISTEN: begin
        if (in_pulse_q && (pcount_q != CNT_MAX)) begin
          pcount_d = pcount_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
        if (rise) begin
          in_pulse_d = 1'b1;
          pcount_d   = {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end else if (fall && in_pulse_q) begin
          width_d = pcount_d;
        end
        if (timer_inc >= {1'b0, listen_len}) begin
          dist_d  = dist_calc;
          led_d   = ~led_q;
          phase_d = PH_HOLD;
          timer_d = '0;
          hold_end = (cfg_i.hold_us == 16'd0);
        end else begin
          timer_d = timer_inc[TIMER_W-1:0];
        end
      end
      PH_HOLD: begin
        if (timer_inc >= {1'b0, cfg_i.hold_us}) begin
          hold_end = 1'b1;
        end else begin
          timer_d = timer_inc[TIMER_W-1:0];
        end
      end
      default: begin
        // trigger phase; a stray code restarts here too
        if (timer_inc >= {{(TIMER_W-7){1'b0}}, trig_len}) begin
          phase_d    = PH_LISTEN;
          timer_d    = '0;
          in_pulse_d = 1'b0;
        end else begin
          timer_d = timer_inc[TIMER_W-1:0];
        end
      end
    endcase

    if (hold_end) begin
      led_d   = ~led_d;
      motor_d = (dist_d >= cfg_i.near_cm);
      phase_d = PH_TRIG;
      timer_d = '0;
    end
  end

  // per-phase outputs
  always_comb begin
    trig   = 1'b0;
    update = 1'b0;
    unique case (phase_q)
      PH_LISTEN: update = (timer_inc >= {1'b0, listen_len});
      PH_HOLD:   update = 1'b0;
      default:   trig   = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TRIG;
      timer_q     <= '0;
      echo_prev_q <= 1'b0;
      in_pulse_q  <= 1'b0;
      pcount_q    <= '0;
      width_q     <= '0;
      dist_q      <= '0;
      motor_q     <= 1'b0;
      led_q       <= 1'b0;
    end else if (tick_i) begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      echo_prev_q <= echo_i;
      in_pulse_q  <= in_pulse_d;
      pcount_q    <= pcount_d;
      width_q     <= width_d;
      dist_q      <= dist_d;
      motor_q     <= motor_d;
      led_q       <= led_d;
    end
  end

  assign res_o.trigger_out     = trig;
  assign res_o.motor_on        = motor_d;
  assign res_o.led_out         = led_d;
  assign res_o.distance_cm     = dist_d;
  assign res_o.distance_update = update;

  `URC_ASSERT(a_update_from_listen, update |-> (phase_q == PH_LISTEN),
              "distance published outside listen window")
  `URC_ASSERT_NEXT(a_pulse_clear, tick_i && (phase_q == PH_TRIG) && (phase_d == PH_LISTEN),
                   !in_pulse_q, "pulse flag not cleared at window start")

endmodule

[hdl/urc_skid.sv]
// ---------------------------------------------------------------------------
// urc_skid
// Two-entry result buffer; decouples the request side from output stall.
// ---------------------------------------------------------------------------
module urc_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  urc_pkg::res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          stall_i,
  output urc_pkg::res_t data_o
);
  import urc_pkg::*;

  `include "ultrasonic_range_cutoff_unit_assert.svh"

  logic [1:0] count_q, count_d;
  res_t       head_q, spare_q;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o & ~stall_i;
  assign count_d = count_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (count_q == 2'd2) begin
        head_q <= spare_q;
      end else if (push_i) begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        spare_q <= data_i;
      end
    end
  end

  assign data_o = head_q;

  `URC_ASSERT(a_no_overflow, push_i |-> (count_q != 2'd2), "request pushed into full buffer")
  `URC_ASSERT_NEXT(a_head_moves, pop && (count_q == 2'd2), data_o == $past(spare_q),
                   "buffered result lost on pop")

endmodule
